/* src/bpte_pkg.sv */
// ----------------------------------------------------------------------------
// bpte_pkg
// Types, codes and helpers shared by the primitive tag encoder stages.
// ----------------------------------------------------------------------------
package bpte_pkg;

  localparam int MaxBytes = 10;

  localparam logic [3:0] OP_NULL    = 4'd0;
  localparam logic [3:0] OP_BOOL    = 4'd1;
  localparam logic [3:0] OP_UNS     = 4'd2;
  localparam logic [3:0] OP_SGN     = 4'd3;
  localparam logic [3:0] OP_REAL    = 4'd4;
  localparam logic [3:0] OP_DOUBLE  = 4'd5;
  localparam logic [3:0] OP_ENUM    = 4'd6;
  localparam logic [3:0] OP_DATE    = 4'd7;
  localparam logic [3:0] OP_TIME    = 4'd8;
  localparam logic [3:0] OP_OBJID   = 4'd9;
  localparam logic [3:0] OP_CTX_UNS = 4'd10;
  localparam logic [3:0] OP_CTX_ENM = 4'd11;
  localparam logic [3:0] OP_CTX_SGN = 4'd12;
  localparam logic [3:0] OP_CTX_BOL = 4'd13;
  localparam logic [3:0] OP_OPEN    = 4'd14;
  localparam logic [3:0] OP_CLOSE   = 4'd15;

  localparam logic [7:0]  ClassCtx    = 8'h08;
  localparam logic [7:0]  ExtTag      = 8'hF0;
  localparam logic [7:0]  TagReserved = 8'd255;
  localparam logic [15:0] YearUnspec  = 16'd65535;
  localparam logic [15:0] YearMin     = 16'd1900;
  localparam logic [15:0] YearMax     = 16'd2154;
  localparam logic [15:0] ObjTypeMax  = 16'd1023;
  localparam logic [63:0] ObjInstMax  = 64'h3F_FFFF;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_NO_ROOM = 2'd2,
    ST_RESERVED = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    MODE_APP   = 2'd0,
    MODE_CTX   = 2'd1,
    MODE_OPEN  = 2'd2,
    MODE_CLOSE = 2'd3
  } mode_e;

  typedef struct packed {
    logic [3:0]  opcode;
    logic [7:0]  tag_number;
    logic [63:0] value;
    logic [15:0] object_type;
    logic [15:0] part_one;
    logic [7:0]  part_two;
    logic [7:0]  part_three;
    logic [7:0]  part_four;
    logic [7:0]  room;
  } req_t;

  // after decode: content octets, element 0 goes first
  typedef struct packed {
    status_e         status;
    mode_e           mode;
    logic [7:0]      tag;
    logic [3:0]      clen;
    logic [3:0]      lvt;
    logic [7:0][7:0] content;
    logic [7:0]      room;
  } dec_t;

  typedef struct packed {
    status_e         status;
    logic [2:0][7:0] hdr;
    logic [1:0]      hlen;
    logic [3:0]      total;
    logic [7:0][7:0] content;
  } hdr_t;

  typedef struct packed {
    status_e                  status;
    logic [3:0]               count;
    logic [MaxBytes-1:0][7:0] octets;
  } pkt_t;

endpackage

/* src/bpte_decode.sv */
// ----------------------------------------------------------------------------
// bpte_decode
// Stage one: range checks, reserved tag check and content octets.
// ----------------------------------------------------------------------------
module bpte_decode
  import bpte_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic valid_i,
  output logic ready_o,
  input  req_t req_i,
  output logic valid_o,
  input  logic ready_i,
  output dec_t dec_o
);

  logic valid_q;
  dec_t dec_q, dec_d;

  // fewest big-endian octets; signed values keep their sign bit
  function automatic logic [2:0] min_len(logic [31:0] v, logic sgn);
    logic [31:0] m;
    m = sgn ? ((v[31] ? ~v : v) << 1) : v;
    if (m[31:24] != 8'd0)      min_len = 3'd4;
    else if (m[23:16] != 8'd0) min_len = 3'd3;
    else if (m[15:8] != 8'd0)  min_len = 3'd2;
    else                       min_len = 3'd1;
  endfunction

  function automatic logic [7:0][7:0] int_octets(logic [31:0] v, logic [2:0] n);
    logic [7:0][7:0] c;
    c = '0;
    case (n)
      3'd1: c[0] = v[7:0];
      3'd2: begin
        c[0] = v[15:8];  c[1] = v[7:0];
      end
      3'd3: begin
        c[0] = v[23:16]; c[1] = v[15:8]; c[2] = v[7:0];
      end
      default: begin
        c[0] = v[31:24]; c[1] = v[23:16]; c[2] = v[15:8]; c[3] = v[7:0];
      end
    endcase
    return c;
  endfunction

  always_comb begin
    logic [31:0]     lo;
    logic [2:0]      n;
    logic            is_sgn;
    logic            nz;
    logic            bad;
    logic [7:0]      apptag;
    logic [31:0]     w;
    logic [7:0][7:0] hi_c;
    logic [7:0][7:0] lo_c;
    lo     = req_i.value[31:0];
    nz     = req_i.value != 64'd0;
    is_sgn = (req_i.opcode == OP_SGN) || (req_i.opcode == OP_CTX_SGN);
    n      = min_len(lo, is_sgn);
    hi_c   = int_octets(req_i.value[63:32], 3'd4);
    lo_c   = int_octets(lo, 3'd4);
    bad    = 1'b0;
    apptag = 8'd0;
    w      = 32'd0;
    dec_d  = '0;
    dec_d.room = req_i.room;
    dec_d.mode = MODE_APP;
    case (req_i.opcode)
      OP_NULL: apptag = 8'd0;
      OP_BOOL: begin
        apptag    = 8'd1;
        dec_d.lvt = {3'd0, nz};
      end
      OP_UNS, OP_SGN, OP_ENUM: begin
        apptag = (req_i.opcode == OP_ENUM) ? 8'd9 : {4'd0, req_i.opcode};
        dec_d.clen    = {1'b0, n};
        dec_d.content = int_octets(lo, n);
      end
      OP_REAL: begin
        apptag = 8'd4;
        dec_d.clen    = 4'd4;
        dec_d.content = lo_c;
      end
      OP_DOUBLE: begin
        apptag = 8'd5;
        dec_d.clen    = 4'd8;
        // upper word first
        dec_d.content = {lo_c[3:0], hi_c[3:0]};
      end
      OP_DATE: begin
        apptag = 8'd10;
        if (req_i.part_one == YearUnspec) w[31:24] = 8'd255;
        else if (req_i.part_one >= YearMin && req_i.part_one <= YearMax)
          w[31:24] = 8'(req_i.part_one - YearMin);
        else bad = 1'b1;
        if (!((req_i.part_two >= 8'd1 && req_i.part_two <= 8'd14) ||
              req_i.part_two == 8'd255)) bad = 1'b1;
        if (!((req_i.part_three >= 8'd1 && req_i.part_three <= 8'd34) ||
              req_i.part_three == 8'd255)) bad = 1'b1;
        if (!((req_i.part_four >= 8'd1 && req_i.part_four <= 8'd7) ||
              req_i.part_four == 8'd255)) bad = 1'b1;
        w[23:0] = {req_i.part_two, req_i.part_three, req_i.part_four};
        dec_d.clen    = 4'd4;
        dec_d.content = int_octets(w, 3'd4);
      end
      OP_TIME: begin
        apptag = 8'd11;
        if (!(req_i.part_one <= 16'd23 || req_i.part_one == 16'd255)) bad = 1'b1;
        if (!(req_i.part_two <= 8'd59 || req_i.part_two == 8'd255)) bad = 1'b1;
        if (!(req_i.part_three <= 8'd59 || req_i.part_three == 8'd255)) bad = 1'b1;
        if (!(req_i.part_four <= 8'd99 || req_i.part_four == 8'd255)) bad = 1'b1;
        w = {req_i.part_one[7:0], req_i.part_two, req_i.part_three, req_i.part_four};
        dec_d.clen    = 4'd4;
        dec_d.content = int_octets(w, 3'd4);
      end
      OP_OBJID: begin
        apptag = 8'd12;
        if (req_i.object_type > ObjTypeMax || req_i.value > ObjInstMax) bad = 1'b1;
        w = {req_i.object_type[9:0], lo[21:0]};
        dec_d.clen    = 4'd4;
        dec_d.content = int_octets(w, 3'd4);
      end
      OP_CTX_UNS, OP_CTX_ENM, OP_CTX_SGN: begin
        dec_d.mode    = MODE_CTX;
        dec_d.clen    = {1'b0, n};
        dec_d.content = int_octets(lo, n);
      end
      OP_CTX_BOL: begin
        dec_d.mode       = MODE_CTX;
        dec_d.clen       = 4'd1;
        dec_d.content[0] = {7'd0, nz};
      end
      OP_OPEN:  dec_d.mode = MODE_OPEN;
      default:  dec_d.mode = MODE_CLOSE;
    endcase
    if (dec_d.mode == MODE_APP) begin
      dec_d.tag = apptag;
      if (req_i.opcode != OP_BOOL) dec_d.lvt = dec_d.clen;
    end else begin
      dec_d.tag = req_i.tag_number;
      dec_d.lvt = dec_d.clen;
    end
    if (bad) dec_d.status = ST_INVALID;
    else if (dec_d.mode != MODE_APP && req_i.tag_number == TagReserved)
      dec_d.status = ST_RESERVED;
    else dec_d.status = ST_OK;
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      dec_q <= dec_d;
    end
  end

  assign valid_o = valid_q;
  assign dec_o   = dec_q;

endmodule

/* src/bpte_header.sv */
// ----------------------------------------------------------------------------
// bpte_header
// Stage two: tag header octets and the room check.
// ----------------------------------------------------------------------------
module bpte_header
  import bpte_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic valid_i,
  output logic ready_o,
  input  dec_t dec_i,
  output logic valid_o,
  input  logic ready_i,
  output hdr_t hdr_o
);

  logic valid_q;
  hdr_t hdr_q, hdr_d;

  always_comb begin
    logic [7:0] h0;
    logic [1:0] n;
    h0    = (dec_i.mode == MODE_APP) ? 8'h00 : ClassCtx;
    n     = 2'd1;
    hdr_d = '0;
    hdr_d.content = dec_i.content;
    if (dec_i.tag < 8'd15) begin
      h0 = h0 | {dec_i.tag[3:0], 4'd0};
    end else begin
      h0 = h0 | ExtTag;
      hdr_d.hdr[n] = dec_i.tag;
      n = n + 2'd1;
    end
    if (dec_i.mode == MODE_OPEN) begin
      h0 = h0 | 8'd6;
    end else if (dec_i.mode == MODE_CLOSE) begin
      h0 = h0 | 8'd7;
    end else if (dec_i.lvt < 4'd5) begin
      h0 = h0 | {5'd0, dec_i.lvt[2:0]};
    end else begin
      // extended length octet
      h0 = h0 | 8'd5;
      hdr_d.hdr[n] = {4'd0, dec_i.lvt};
      n = n + 2'd1;
    end
    hdr_d.hdr[0] = h0;
    hdr_d.hlen   = n;
    hdr_d.total  = {2'd0, n} + dec_i.clen;
    if (dec_i.status != ST_OK) hdr_d.status = dec_i.status;
    else if ({4'd0, hdr_d.total} > dec_i.room) hdr_d.status = ST_NO_ROOM;
    else hdr_d.status = ST_OK;
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      hdr_q <= hdr_d;
    end
  end

  assign valid_o = valid_q;
  assign hdr_o   = hdr_q;

endmodule

/* src/bpte_pack.sv */
// ----------------------------------------------------------------------------
// bpte_pack
// Stage three: joins header and content into one octet row with a count.
// ----------------------------------------------------------------------------
module bpte_pack
  import bpte_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic valid_i,
  output logic ready_o,
  input  hdr_t hdr_i,
  output logic valid_o,
  input  logic ready_i,
  output pkt_t pkt_o
);

  logic valid_q;
  pkt_t pkt_q, pkt_d;

  always_comb begin
    logic [3:0] k;
    pkt_d        = '0;
    pkt_d.status = hdr_i.status;
    k            = 4'd0;
    if (hdr_i.status != ST_OK) begin
      // failure: a single zero octet carrying the status
      pkt_d.count = 4'd1;
    end else begin
      pkt_d.count = hdr_i.total;
      for (int i = 0; i < MaxBytes; i++) begin
        k = 4'(i) - {2'd0, hdr_i.hlen};
        if (4'(i) < {2'd0, hdr_i.hlen}) pkt_d.octets[i] = hdr_i.hdr[2'(i)];
        else if (k < 4'd8) pkt_d.octets[i] = hdr_i.content[k[2:0]];
        else pkt_d.octets[i] = 8'd0;
      end
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      pkt_q <= pkt_d;
    end
  end

  assign valid_o = valid_q;
  assign pkt_o   = pkt_q;

endmodule

/* src/bpte_serial.sv */
// ----------------------------------------------------------------------------
// bpte_serial
// Output stage: holds one octet row and sends it out one octet per item.
// ----------------------------------------------------------------------------
module bpte_serial
  import bpte_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  output logic       ready_o,
  input  pkt_t       pkt_i,
  output logic       m_tvalid_o,
  input  logic       m_tready_i,
  output logic [7:0] m_tdata_o,
  output logic       m_tlast_o,
  output logic [1:0] m_tuser_o
);

  logic                     busy_q;
  logic [3:0]               idx_q, cnt_q;
  logic [MaxBytes-1:0][7:0] row_q;
  status_e                  status_q;
  logic                     last, take;

  assign last    = idx_q == (cnt_q - 4'd1);
  assign take    = busy_q && m_tready_i;
  // next row may load in the same cycle the final octet leaves
  assign ready_o = !busy_q || (take && last);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= 4'd0;
    end else if (ready_o) begin
      busy_q <= valid_i;
      idx_q  <= 4'd0;
    end else if (take) begin
      idx_q <= idx_q + 4'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      row_q    <= pkt_i.octets;
      cnt_q    <= pkt_i.count;
      status_q <= pkt_i.status;
    end
  end

  assign m_tvalid_o = busy_q;
  assign m_tdata_o  = row_q[idx_q];
  assign m_tlast_o  = last;
  assign m_tuser_o  = status_q;

`ifndef SYNTH
  a_idx_in_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (idx_q < cnt_q && cnt_q != 4'd0 && cnt_q <= 4'(MaxBytes)))
    else $error("octet index outside the row");

  a_fail_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && status_q != ST_OK) |-> (cnt_q == 4'd1 && m_tdata_o == 8'd0))
    else $error("failure item is not a single zero octet");

  a_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && !last) |=> (busy_q && idx_q == $past(idx_q) + 4'd1))
    else $error("octet index did not advance");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && !m_tready_i) |=> (busy_q && $stable(idx_q)))
    else $error("stalled row moved");
`endif

endmodule

/* src/bacnet_primitive_tag_encoder_top.sv */
// Path: a request is registered in the decode, header, pack and serial stages in turn.
// Throughput: one octet per cycle while m_tready_i is high; a request yields 1 octet
// on a failure and up to 10 otherwise, and the output stage loads the next row as its
// final octet leaves. Decode, header and pack take one request a cycle unless stalled.
// Reset: asynchronous, active low; clears all stage valid bits, no request pending.
// ----------------------------------------------------------------------------
// bacnet_primitive_tag_encoder_top
// Four-stage encoder for BACnet primitive application and context tags.
// ----------------------------------------------------------------------------
module bacnet_primitive_tag_encoder_top
  import bpte_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_tvalid_i,
  output logic         s_tready_o,
  // opcode[3:0], tag_number[11:4], value[75:12], object_type[91:76],
  // part_one[107:92], part_two[115:108], part_three[123:116],
  // part_four[131:124], room[139:132], zero[143:140]
  input  logic [143:0] s_tdata_i,
  output logic         m_tvalid_o,
  input  logic         m_tready_i,
  // out_byte[7:0]
  output logic [7:0]   m_tdata_o,
  output logic         m_tlast_o,
  // status[1:0]
  output logic [1:0]   m_tuser_o
);

  req_t req;
  dec_t dec;
  hdr_t hdr;
  pkt_t pkt;
  logic dec_v, hdr_v, pkt_v;
  logic hdr_rdy, pkt_rdy, ser_rdy;

  assign req.opcode      = s_tdata_i[3:0];
  assign req.tag_number  = s_tdata_i[11:4];
  assign req.value       = s_tdata_i[75:12];
  assign req.object_type = s_tdata_i[91:76];
  assign req.part_one    = s_tdata_i[107:92];
  assign req.part_two    = s_tdata_i[115:108];
  assign req.part_three  = s_tdata_i[123:116];
  assign req.part_four   = s_tdata_i[131:124];
  assign req.room        = s_tdata_i[139:132];

  bpte_decode u_decode (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_tvalid_i),
    .ready_o (s_tready_o),
    .req_i   (req),
    .valid_o (dec_v),
    .ready_i (hdr_rdy),
    .dec_o   (dec)
  );

  bpte_header u_header (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (dec_v),
    .ready_o (hdr_rdy),
    .dec_i   (dec),
    .valid_o (hdr_v),
    .ready_i (pkt_rdy),
    .hdr_o   (hdr)
  );

  bpte_pack u_pack (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (hdr_v),
    .ready_o (pkt_rdy),
    .hdr_i   (hdr),
    .valid_o (pkt_v),
    .ready_i (ser_rdy),
    .pkt_o   (pkt)
  );

  bpte_serial u_serial (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (pkt_v),
    .ready_o    (ser_rdy),
    .pkt_i      (pkt),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o),
    .m_tlast_o  (m_tlast_o),
    .m_tuser_o  (m_tuser_o)
  );

endmodule

/* verif/bpte_tb_pkg.sv */
// ----------------------------------------------------------------------------
// bpte_tb_pkg
// Octet predictor and scoreboard for the primitive tag encoder testbench.
// Each accepted request is turned into the octets the encoder should emit;
// each octet seen at the output is checked against the oldest one due.
// ----------------------------------------------------------------------------
package bpte_tb_pkg;
  import bpte_pkg::*;

  // application tag numbers
  localparam logic [7:0] AppNull   = 8'd0;
  localparam logic [7:0] AppBool   = 8'd1;
  localparam logic [7:0] AppUns    = 8'd2;
  localparam logic [7:0] AppSgn    = 8'd3;
  localparam logic [7:0] AppReal   = 8'd4;
  localparam logic [7:0] AppDouble = 8'd5;
  localparam logic [7:0] AppEnum   = 8'd9;
  localparam logic [7:0] AppDate   = 8'd10;
  localparam logic [7:0] AppTime   = 8'd11;
  localparam logic [7:0] AppObjId  = 8'd12;

  // length/value/type field codes
  localparam int unsigned LvtExt   = 5;
  localparam logic [7:0]  LvtOpen  = 8'd6;
  localparam logic [7:0]  LvtClose = 8'd7;

  localparam logic [7:0] TagExtFrom  = 8'd15;
  localparam logic [7:0] FieldUnspec = 8'hFF;

  typedef struct {
    logic [7:0] octet;
    logic       last;
    status_e    status;
  } octet_due_t;

  class tag_octet_ledger;
    octet_due_t  due_octets[$];
    int unsigned mismatches;
    int unsigned octets_checked;
    int unsigned requests_seen;
    int unsigned status_seen[4];

    // fewest big-endian octets holding v (two's complement when sgn)
    function int unsigned int_width(logic [31:0] v, bit sgn);
      logic [31:0] m;
      int unsigned n;
      m = sgn ? ((v[31] ? ~v : v) << 1) : v;
      n = 1;
      while (n < 4 && (m >> (8 * n)) != 0) n++;
      return n;
    endfunction

    function void note_request(req_t r);
      logic [63:0] body;
      logic [7:0]  hdr[3];
      logic [7:0]  tag;
      logic [7:0]  yr;
      logic [31:0] lo;
      int unsigned blen;
      int unsigned hlen;
      int unsigned total;
      int unsigned lvt;
      mode_e       mode;
      status_e     verdict;
      octet_due_t  o;
      lo      = r.value[31:0];
      body    = '0;
      blen    = 0;
      lvt     = 0;
      yr      = 8'h00;
      mode    = MODE_APP;
      verdict = ST_OK;
      tag     = r.tag_number;
      requests_seen++;

      case (r.opcode)
        OP_NULL: tag = AppNull;
        OP_BOOL: begin
          tag = AppBool;
          lvt = (r.value != 0) ? 1 : 0;
        end
        OP_UNS: begin
          tag  = AppUns;
          blen = int_width(lo, 1'b0);
          body = 64'(lo);
        end
        OP_SGN: begin
          tag  = AppSgn;
          blen = int_width(lo, 1'b1);
          body = 64'(lo);
        end
        OP_REAL: begin
          tag  = AppReal;
          blen = 4;
          body = 64'(lo);
        end
        OP_DOUBLE: begin
          tag  = AppDouble;
          blen = 8;
          body = r.value;
        end
        OP_ENUM: begin
          tag  = AppEnum;
          blen = int_width(lo, 1'b0);
          body = 64'(lo);
        end
        OP_DATE: begin
          tag  = AppDate;
          blen = 4;
          if (r.part_one == YearUnspec) yr = FieldUnspec;
          else if (r.part_one >= YearMin && r.part_one <= YearMax) yr = 8'(r.part_one - YearMin);
          else verdict = ST_INVALID;
          if (!((r.part_two >= 1 && r.part_two <= 14) || r.part_two == FieldUnspec))
            verdict = ST_INVALID;
          if (!((r.part_three >= 1 && r.part_three <= 34) || r.part_three == FieldUnspec))
            verdict = ST_INVALID;
          if (!((r.part_four >= 1 && r.part_four <= 7) || r.part_four == FieldUnspec))
            verdict = ST_INVALID;
          body = {32'h0, yr, r.part_two, r.part_three, r.part_four};
        end
        OP_TIME: begin
          tag  = AppTime;
          blen = 4;
          if (!(r.part_one <= 23 || r.part_one == 16'(FieldUnspec))) verdict = ST_INVALID;
          if (!(r.part_two <= 59 || r.part_two == FieldUnspec)) verdict = ST_INVALID;
          if (!(r.part_three <= 59 || r.part_three == FieldUnspec)) verdict = ST_INVALID;
          if (!(r.part_four <= 99 || r.part_four == FieldUnspec)) verdict = ST_INVALID;
          body = {32'h0, r.part_one[7:0], r.part_two, r.part_three, r.part_four};
        end
        OP_OBJID: begin
          tag  = AppObjId;
          blen = 4;
          if (r.object_type > ObjTypeMax || r.value > ObjInstMax) verdict = ST_INVALID;
          body = {32'h0, r.object_type[9:0], lo[21:0]};
        end
        OP_CTX_UNS, OP_CTX_ENM: begin
          mode = MODE_CTX;
          blen = int_width(lo, 1'b0);
          body = 64'(lo);
        end
        OP_CTX_SGN: begin
          mode = MODE_CTX;
          blen = int_width(lo, 1'b1);
          body = 64'(lo);
        end
        OP_CTX_BOL: begin
          mode = MODE_CTX;
          blen = 1;
          body = {63'd0, (r.value != 0)};
        end
        OP_OPEN:  mode = MODE_OPEN;
        default:  mode = MODE_CLOSE;
      endcase

      if (verdict == ST_OK && mode != MODE_APP && tag == TagReserved) verdict = ST_RESERVED;
      // boolean carries its value in the length field, everything else its length
      if (r.opcode != OP_BOOL) lvt = blen;

      hlen   = 1;
      hdr[0] = (mode == MODE_APP) ? 8'h00 : ClassCtx;
      if (tag < TagExtFrom) begin
        hdr[0] = hdr[0] | {tag[3:0], 4'h0};
      end else begin
        hdr[0]    = hdr[0] | ExtTag;
        hdr[hlen] = tag;
        hlen++;
      end
      case (mode)
        MODE_OPEN:  hdr[0] = hdr[0] | LvtOpen;
        MODE_CLOSE: hdr[0] = hdr[0] | LvtClose;
        default: begin
          if (lvt < LvtExt) begin
            hdr[0] = hdr[0] | 8'(lvt);
          end else begin
            hdr[0]    = hdr[0] | 8'(LvtExt);
            hdr[hlen] = 8'(lvt);
            hlen++;
          end
        end
      endcase

      total = hlen + blen;
      if (verdict == ST_OK && total > r.room) verdict = ST_NO_ROOM;
      status_seen[verdict]++;

      if (verdict != ST_OK) begin
        o.octet  = 8'h00;
        o.last   = 1'b1;
        o.status = verdict;
        due_octets.push_back(o);
      end else begin
        for (int unsigned i = 0; i < total; i++) begin
          o.octet  = (i < hlen) ? hdr[i] : body[8 * (blen - 1 - (i - hlen)) +: 8];
          o.last   = (i + 1 == total);
          o.status = ST_OK;
          due_octets.push_back(o);
        end
      end
    endfunction

    function void check_octet(logic [7:0] octet, logic last, logic [1:0] status);
      octet_due_t o;
      octets_checked++;
      if (due_octets.size() == 0) begin
        $error("unexpected octet 0x%02h (last %0b, status %0d)", octet, last, status);
        mismatches++;
        return;
      end
      o = due_octets.pop_front();
      if (octet !== o.octet) begin
        $error("out_byte: expected 0x%02h, got 0x%02h", o.octet, octet);
        mismatches++;
      end
      if (last !== o.last) begin
        $error("last_byte: expected %0b, got %0b", o.last, last);
        mismatches++;
      end
      if (status !== o.status) begin
        $error("status: expected %0d, got %0d", o.status, status);
        mismatches++;
      end
    endfunction

    function int unsigned pending();
      return due_octets.size();
    endfunction
  endclass

endpackage

/* verif/tb_bacnet_primitive_tag_encoder_top.sv */
// ----------------------------------------------------------------------------
// tb_bacnet_primitive_tag_encoder_top
// Self-checking bench for the primitive tag encoder: a directed set of
// boundary requests, then random requests under three back-pressure mixes,
// every output octet checked in order against the predicted stream.
// ----------------------------------------------------------------------------
module tb_bacnet_primitive_tag_encoder_top;
  timeunit 1ns;
  timeprecision 1ps;

  import bpte_pkg::*;
  import bpte_tb_pkg::*;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [143:0] s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [7:0]   m_tdata;
  logic         m_tlast;
  logic [1:0]   m_tuser;

  int unsigned tx_idle_pct = 11;
  int unsigned rx_idle_pct = 73;

  tag_octet_ledger board;

  bacnet_primitive_tag_encoder_top u_top (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .s_tvalid_i (s_tvalid),
    .s_tready_o (s_tready),
    .s_tdata_i  (s_tdata),
    .m_tvalid_o (m_tvalid),
    .m_tready_i (m_tready),
    .m_tdata_o  (m_tdata),
    .m_tlast_o  (m_tlast),
    .m_tuser_o  (m_tuser)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // outputs are stable between edges; an octet seen here is taken at the next edge
  always @(negedge clk) begin
    if (rst_n && m_tvalid && m_tready) board.check_octet(m_tdata, m_tlast, m_tuser);
  end

  function automatic req_t make_req(logic [3:0] op, logic [7:0] tag, logic [63:0] value,
                                    logic [15:0] otype, logic [15:0] p1, logic [7:0] p2,
                                    logic [7:0] p3, logic [7:0] p4, logic [7:0] room);
    req_t r;
    r.opcode      = op;
    r.tag_number  = tag;
    r.value       = value;
    r.object_type = otype;
    r.part_one    = p1;
    r.part_two    = p2;
    r.part_three  = p3;
    r.part_four   = p4;
    r.room        = room;
    return r;
  endfunction

  function automatic req_t random_request();
    req_t        r;
    logic [31:0] lo;
    int unsigned w;
    int unsigned pick;
    r.opcode = 4'($urandom_range(15));
    pick = $urandom_range(99);
    if (pick < 60) r.tag_number = 8'($urandom_range(14));
    else if (pick < 80) r.tag_number = 8'($urandom_range(17, 13));
    else if (pick < 88) r.tag_number = TagReserved;
    else r.tag_number = 8'($urandom);

    // integers sized to 1..4 octets, sign-extended or zero-filled above
    lo = $urandom;
    w  = $urandom_range(4, 1);
    if (w < 4) begin
      if ($urandom_range(1) == 1) lo = lo | (32'hFFFF_FFFF << (8 * w));
      else lo = lo & ~(32'hFFFF_FFFF << (8 * w));
    end
    r.value = {(($urandom_range(3) == 0) ? 32'($urandom) : 32'h0), lo};
    if ($urandom_range(15) == 0) r.value = '0;

    r.object_type = 16'($urandom);
    if (r.opcode == OP_OBJID && $urandom_range(9) != 0) begin
      r.object_type = 16'($urandom_range(ObjTypeMax));
      r.value       = {32'h0, 32'($urandom_range(ObjInstMax[31:0]))};
    end

    r.part_one   = 16'($urandom);
    r.part_two   = 8'($urandom);
    r.part_three = 8'($urandom);
    r.part_four  = 8'($urandom);
    if (r.opcode == OP_DATE) begin
      if ($urandom_range(19) != 0)
        r.part_one = ($urandom_range(7) == 0) ? YearUnspec : 16'($urandom_range(YearMax, YearMin));
      if ($urandom_range(19) != 0)
        r.part_two = ($urandom_range(7) == 0) ? FieldUnspec : 8'($urandom_range(14, 1));
      if ($urandom_range(19) != 0)
        r.part_three = ($urandom_range(7) == 0) ? FieldUnspec : 8'($urandom_range(34, 1));
      if ($urandom_range(19) != 0)
        r.part_four = ($urandom_range(7) == 0) ? FieldUnspec : 8'($urandom_range(7, 1));
    end else if (r.opcode == OP_TIME) begin
      if ($urandom_range(19) != 0)
        r.part_one = ($urandom_range(7) == 0) ? 16'(FieldUnspec) : 16'($urandom_range(23));
      if ($urandom_range(19) != 0)
        r.part_two = ($urandom_range(7) == 0) ? FieldUnspec : 8'($urandom_range(59));
      if ($urandom_range(19) != 0)
        r.part_three = ($urandom_range(7) == 0) ? FieldUnspec : 8'($urandom_range(59));
      if ($urandom_range(19) != 0)
        r.part_four = ($urandom_range(7) == 0) ? FieldUnspec : 8'($urandom_range(99));
    end

    r.room = ($urandom_range(4) == 0) ? 8'($urandom_range(10)) : 8'($urandom_range(255, 10));
    return r;
  endfunction

  // called at a rising edge; returns at the edge where the item is taken
  task automatic send_request(input req_t r);
    bit taken;
    if ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {4'h0, r.room, r.part_four, r.part_three, r.part_two, r.part_one,
                 r.object_type, r.value, r.tag_number, r.opcode};
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = s_tready;
      @(posedge clk);
    end
    board.note_request(r);
  endtask

  initial begin
    board = new();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: field extremes, every opcode, range and tag corner cases
    send_request(make_req(OP_NULL, 8'd0, 64'h0, 16'h0, 16'h0, 8'h0, 8'h0, 8'h0, 8'd255));
    send_request(make_req(OP_BOOL, 8'd0, 64'h0, 16'h0, 16'h0, 8'h0, 8'h0, 8'h0, 8'd1));
    send_request(make_req(OP_BOOL, 8'hFF, 64'h8000_0000_0000_0000, 16'hFFFF, 16'hFFFF,
                          8'hFF, 8'hFF, 8'hFF, 8'd1));
    send_request(make_req(OP_UNS, 8'd3, 64'h0, 16'h0, 16'h0, 8'h0, 8'h0, 8'h0, 8'd2));
    send_request(make_req(OP_UNS, 8'd3, 64'hFFFF_FFFF_FFFF_FFFF, 16'h0, 16'h0, 8'h0, 8'h0,
                          8'h0, 8'd5));
    send_request(make_req(OP_SGN, 8'd0, 64'hFFFF_FF80, 16'h0, 16'h0, 8'h0, 8'h0, 8'h0, 8'd9));
    send_request(make_req(OP_SGN, 8'd0, 64'h8000_0000, 16'h0, 16'h0, 8'h0, 8'h0, 8'h0, 8'd9));
    send_request(make_req(OP_SGN, 8'd0, 64'h0000_0080, 16'h0, 16'h0, 8'h0, 8'h0, 8'h0, 8'd9));
    send_request(make_req(OP_REAL, 8'd0, 64'h3F80_0000, 16'h0, 16'h0, 8'h0, 8'h0, 8'h0, 8'd5));
    send_request(make_req(OP_DOUBLE, 8'd0, 64'h0123_4567_89AB_CDEF, 16'h0, 16'h0, 8'h0, 8'h0,
                          8'h0, 8'd10));
    send_request(make_req(OP_DOUBLE, 8'd0, 64'hFEDC_BA98_7654_3210, 16'h0, 16'h0, 8'h0, 8'h0,
                          8'h0, 8'd9));
    send_request(make_req(OP_ENUM, 8'd0, 64'h0001_0000, 16'h0, 16'h0, 8'h0, 8'h0, 8'h0, 8'd4));
    send_request(make_req(OP_DATE, 8'd0, 64'h0, 16'h0, YearMax, 8'd14, 8'd34, 8'd7, 8'd5));
    send_request(make_req(OP_DATE, 8'd0, 64'h0, 16'h0, YearUnspec, FieldUnspec, FieldUnspec,
                          FieldUnspec, 8'd5));
    send_request(make_req(OP_DATE, 8'd0, 64'h0, 16'h0, 16'd1899, 8'd1, 8'd1, 8'd1, 8'd5));
    send_request(make_req(OP_TIME, 8'd0, 64'h0, 16'h0, 16'd23, 8'd59, 8'd59, 8'd99, 8'd5));
    send_request(make_req(OP_TIME, 8'd0, 64'h0, 16'h0, 16'd256, 8'd0, 8'd0, 8'd0, 8'd5));
    send_request(make_req(OP_OBJID, 8'd0, ObjInstMax, ObjTypeMax, 16'h0, 8'h0, 8'h0, 8'h0,
                          8'd5));
    send_request(make_req(OP_OBJID, 8'd0, 64'h0001_0000_0000_0000, 16'd8, 16'h0, 8'h0, 8'h0,
                          8'h0, 8'd5));
    send_request(make_req(OP_CTX_UNS, 8'd14, 64'h1234, 16'h0, 16'h0, 8'h0, 8'h0, 8'h0, 8'd3));
    send_request(make_req(OP_CTX_ENM, 8'd15, 64'hFF_FFFF, 16'h0, 16'h0, 8'h0, 8'h0, 8'h0,
                          8'd5));
    send_request(make_req(OP_CTX_SGN, 8'd254, 64'hFFFF_FFFF, 16'h0, 16'h0, 8'h0, 8'h0, 8'h0,
                          8'd3));
    send_request(make_req(OP_CTX_BOL, TagReserved, 64'h1, 16'h0, 16'h0, 8'h0, 8'h0, 8'h0,
                          8'd255));
    send_request(make_req(OP_OPEN, 8'd0, 64'h0, 16'h0, 16'h0, 8'h0, 8'h0, 8'h0, 8'd1));
    send_request(make_req(OP_CLOSE, 8'd200, 64'h0, 16'h0, 16'h0, 8'h0, 8'h0, 8'h0, 8'd0));

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          tx_idle_pct = 11;
          rx_idle_pct = 73;
        end
        1: begin
          tx_idle_pct = 73;
          rx_idle_pct = 11;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      repeat (160) send_request(random_request());
    end
    s_tvalid <= 1'b0;

    while (board.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Encoded %0d requests: %0d ok, %0d bad value, %0d out of room, %0d reserved tag;",
             board.requests_seen, board.status_seen[ST_OK], board.status_seen[ST_INVALID],
             board.status_seen[ST_NO_ROOM], board.status_seen[ST_RESERVED]);
    $display("%0d octets compared over light, heavy and no back-pressure, %0d mismatches.",
             board.octets_checked, board.mismatches);
    if (board.mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("Timed out with %0d octets still due.", board.pending());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
